// File: rtl/eco_pkg.sv
// ----------------------------------------------------------------------------
// eco_pkg
// shared types, constants and table generators of the easing curve evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package eco_pkg;

  // default fixed point and table geometry
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned TABLE_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned OP_W    = 3;
  // exponent shift: integer part of 10*x (at most 10) plus the in-out halving
  localparam int unsigned SHIFT_W = 4;

  // pipeline depth, acceptance to result register
  localparam int unsigned NSTG = 7;

  // series evaluation precision of the table generators
  localparam int unsigned WORK_BITS = 30;
  localparam logic [63:0] WORK_ONE  = 64'd1 << WORK_BITS;
  localparam logic [63:0] PI_W      = 64'd3373259426;
  localparam logic [63:0] LN2_W     = 64'd744261118;

  typedef enum logic [OP_W-1:0] {
    OP_LINEAR,
    OP_QUAD_IN,
    OP_QUAD_OUT,
    OP_QUAD_INOUT,
    OP_EXP_IN,
    OP_EXP_OUT,
    OP_EXP_INOUT,
    OP_SINE
  } op_e;

  // sideband that travels down the pipeline with each transaction
  typedef struct packed {
    op_e  op;
    logic bad;   // progress above 1.0
    logic dbl;   // quadratic product doubled
    logic sub;   // quadratic result taken as 1.0 minus product
    logic inv;   // exponential result taken as 1.0 minus power
  } ctl_t;

  // round a work-precision value to Q.fb, saturating at 1.0
  function automatic logic [63:0] work_to_q(input logic [63:0] r, input int unsigned fb);
    logic [63:0] v;
    logic [63:0] one;
    one = 64'd1 << fb;
    v   = (r + (64'd1 << (WORK_BITS - fb - 1))) >> (WORK_BITS - fb);
    return (v > one) ? one : v;
  endfunction

  // 2^(-i / 2^tb), alternating series of exp(-y)
  function automatic logic [63:0] exp_entry(input int unsigned i, input int unsigned fb,
                                            input int unsigned tb);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    x    = 64'(i) << (WORK_BITS - tb);
    y    = (x * LN2_W) >> WORK_BITS;
    pos  = WORK_ONE;
    neg  = '0;
    term = WORK_ONE;
    for (int unsigned k = 1; k <= 24; k++) begin
      term = ((term * y) >> WORK_BITS) / 64'(k);
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return work_to_q((pos > neg) ? pos - neg : 64'd0, fb);
  endfunction

  // sin(pi * i / 2^(tb+1)), taylor series
  function automatic logic [63:0] sin_entry(input int unsigned i, input int unsigned fb,
                                            input int unsigned tb);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    th   = (PI_W * 64'(i)) >> (tb + 1);
    th2  = (th * th) >> WORK_BITS;
    pos  = th;
    neg  = '0;
    term = th;
    for (int unsigned k = 1; k <= 12; k++) begin
      term = ((term * th2) >> WORK_BITS) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return work_to_q((pos > neg) ? pos - neg : 64'd0, fb);
  endfunction

endpackage

`default_nettype wire

// File: rtl/eco_in_if.sv
// ----------------------------------------------------------------------------
// eco_in_if
// input channel: progress, easing selector and pixel size
// ----------------------------------------------------------------------------
`default_nettype none

interface eco_in_if import eco_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) ();

  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   percent;
  logic [OP_W-1:0]      operation;
  logic [SIZE_W-1:0]    size;

  modport source (output valid, output percent, output operation, output size, input ready);
  modport sink   (input valid, input percent, input operation, input size, output ready);

endinterface

`default_nettype wire

// File: rtl/eco_out_if.sv
// ----------------------------------------------------------------------------
// eco_out_if
// result channel: eased value, pixel position and range flag
// ----------------------------------------------------------------------------
`default_nettype none

interface eco_out_if import eco_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) ();

  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   eased;
  logic [SIZE_W-1:0]    pixel;
  logic                 bad_percent;

  modport source (output valid, output eased, output pixel, output bad_percent, input ready);
  modport sink   (input valid, input eased, input pixel, input bad_percent, output ready);

endinterface

`default_nettype wire

// File: rtl/easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// fixed point easing curves with pixel scaling, seven stage pipeline
// ----------------------------------------------------------------------------
// usage
//   in_i  carries progress (Q1.FRAC_BITS, 1.0 = 1 << FRAC_BITS), the easing
//         mode and a size in pixels; a transaction is taken when valid and
//         ready are both high
//   out_o returns the eased value, round(size * eased) and a flag for
//         progress above 1.0 (eased and pixel are then zero)
//   an accepted transaction passes stages 1 to 7 to out_o; one transaction per
//   cycle is sustained while out_o.ready holds high, with at most one multiplier
//   per stage (quadratic product, interpolation product, pixel product)
//   each stage holds its own valid bit; a stalled receiver freezes the last
//   stage while empty stages ahead keep filling, so in_i.ready falls only
//   once all seven stages hold transactions
//   reset clears the valid bits; no transaction is in flight afterwards
//   powers of two and the sine are interpolated from constant tables of
//   2^TABLE_BITS + 1 entries built at elaboration
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_evaluator import eco_pkg::*; #(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  eco_in_if.sink      in_i,
  eco_out_if.source   out_o
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // pipeline control: stage j may load when empty or when its content moves on
  logic [NSTG:1] vld_q;
  logic [NSTG:1] vld_d;
  logic [NSTG:1] stg_en;

  always_comb begin
    stg_en[NSTG] = !vld_q[NSTG] || out_o.ready;
    for (int j = NSTG - 1; j >= 1; j--) begin
      stg_en[j] = !vld_q[j] || stg_en[j+1];
    end
    vld_d = vld_q;
    if (stg_en[1]) begin
      vld_d[1] = in_i.valid;
    end
    for (int j = 2; j <= NSTG; j++) begin
      if (stg_en[j]) begin
        vld_d[j] = vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = stg_en[1];
  assign out_o.valid = vld_q[NSTG];

  // stage 1: decode
  ctl_t                  ctl1;
  logic [FRAC_BITS:0]    pct1;
  logic [SIZE_W-1:0]     size1;
  logic [FRAC_BITS+1:0]  ma1, mb1;
  logic [TABLE_BITS:0]   idx1;
  logic [FRAC_BITS-1:0]  wgt1;
  logic [SHIFT_W-1:0]    shift1;

  eco_decode #(
    .FRAC_BITS  (FRAC_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .en_i        (stg_en[1]),
    .percent_i   (in_i.percent),
    .operation_i (in_i.operation),
    .size_i      (in_i.size),
    .ctl_o       (ctl1),
    .pct_o       (pct1),
    .size_o      (size1),
    .ma_o        (ma1),
    .mb_o        (mb1),
    .idx_o       (idx1),
    .wgt_o       (wgt1),
    .shift_o     (shift1)
  );

  // stages 2 to 4: tables, quadratic product, interpolation
  ctl_t                  ctl4;
  logic [FRAC_BITS:0]    pct4;
  logic [SIZE_W-1:0]     size4;
  logic [SHIFT_W-1:0]    shift4;
  logic [FRAC_BITS:0]    qe4;
  logic [FRAC_BITS:0]    tv4;

  eco_curve #(
    .FRAC_BITS  (FRAC_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_curve (
    .clk_i   (clk_i),
    .en_i    (stg_en[4:2]),
    .ctl_i   (ctl1),
    .pct_i   (pct1),
    .size_i  (size1),
    .ma_i    (ma1),
    .mb_i    (mb1),
    .idx_i   (idx1),
    .wgt_i   (wgt1),
    .shift_i (shift1),
    .ctl_o   (ctl4),
    .pct_o   (pct4),
    .size_o  (size4),
    .shift_o (shift4),
    .qe_o    (qe4),
    .tv_o    (tv4)
  );

  // stages 5 to 7: mode select and pixel scaling, result register
  eco_output #(
    .FRAC_BITS (FRAC_BITS)
  ) u_output (
    .clk_i   (clk_i),
    .en_i    (stg_en[7:5]),
    .ctl_i   (ctl4),
    .pct_i   (pct4),
    .size_i  (size4),
    .shift_i (shift4),
    .qe_i    (qe4),
    .tv_i    (tv4),
    .eased_o (out_o.eased),
    .pixel_o (out_o.pixel),
    .bad_o   (out_o.bad_percent)
  );

  // out of range progress yields a zero result
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_percent |-> out_o.eased == '0 && out_o.pixel == '0)
    else $error("out of range transaction with nonzero result");

  // eased value never exceeds 1.0
  a_eased_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.eased <= ONE)
    else $error("eased value above 1.0");

  // input backpressure only when every stage is occupied
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &vld_q)
    else $error("input stalled with an empty stage");

  // a held result stays valid on the next cycle
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.pixel))
    else $error("stalled result lost");

endmodule

`default_nettype wire

// File: rtl/eco_decode.sv
// ----------------------------------------------------------------------------
// eco_decode
// stage 1: range check, multiplier operands and table position per mode
// ----------------------------------------------------------------------------
`default_nettype none

module eco_decode import eco_pkg::*; #(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [FRAC_BITS:0]     percent_i,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [SIZE_W-1:0]      size_i,
  output ctl_t                   ctl_o,
  output logic [FRAC_BITS:0]     pct_o,
  output logic [SIZE_W-1:0]      size_o,
  output logic [FRAC_BITS+1:0]   ma_o,
  output logic [FRAC_BITS+1:0]   mb_o,
  output logic [TABLE_BITS:0]    idx_o,
  output logic [FRAC_BITS-1:0]   wgt_o,
  output logic [SHIFT_W-1:0]     shift_o
);

  localparam int unsigned W   = FRAC_BITS + 1;
  localparam int unsigned MW  = FRAC_BITS + 2;
  localparam int unsigned MEW = FRAC_BITS + 4;
  localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

  op_e                         op;
  logic [W-1:0]                q;
  logic [W-1:0]                x;
  logic [W-1:0]                qs;
  logic [MEW-1:0]              m;
  logic                        lo;
  logic [FRAC_BITS+TABLE_BITS-1:0] epos;
  logic [FRAC_BITS+TABLE_BITS:0]   spos;
  ctl_t                        ctl_d;
  logic [MW-1:0]               ma_d, mb_d;
  logic [TABLE_BITS:0]         idx_d;
  logic [FRAC_BITS-1:0]        wgt_d;
  logic [SHIFT_W-1:0]          shift_d;

  always_comb begin
    op   = op_e'(operation_i);
    q    = ONE - percent_i;
    lo   = percent_i < HALF;
    qs   = (percent_i <= HALF) ? percent_i : q;

    ctl_d     = '0;
    ctl_d.op  = op;
    ctl_d.bad = percent_i > ONE;
    ma_d      = MW'(percent_i);
    mb_d      = MW'(percent_i);
    x         = percent_i;

    case (op)
      OP_QUAD_OUT: begin
        ma_d = (MW'(ONE) << 1) - MW'(percent_i);
      end
      OP_QUAD_INOUT: begin
        ctl_d.dbl = 1'b1;
        if (!lo) begin
          ma_d      = MW'(q);
          mb_d      = MW'(q);
          ctl_d.sub = 1'b1;
        end
      end
      OP_EXP_IN: begin
        x = q;
      end
      OP_EXP_OUT: begin
        ctl_d.inv = 1'b1;
      end
      OP_EXP_INOUT: begin
        if (lo) begin
          x = ONE - (percent_i << 1);
        end else begin
          x         = (percent_i << 1) - ONE;
          ctl_d.inv = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // exponent 10*x split into shift count and fraction
    m    = (MEW'(x) << 3) + (MEW'(x) << 1);
    epos = {m[FRAC_BITS-1:0], {TABLE_BITS{1'b0}}};
    spos = {qs[FRAC_BITS-1:0], {(TABLE_BITS + 1){1'b0}}};

    if (op == OP_SINE) begin
      idx_d   = spos[FRAC_BITS+TABLE_BITS:FRAC_BITS];
      wgt_d   = spos[FRAC_BITS-1:0];
      shift_d = '0;
    end else begin
      idx_d   = {1'b0, epos[FRAC_BITS+TABLE_BITS-1:FRAC_BITS]};
      wgt_d   = epos[FRAC_BITS-1:0];
      shift_d = m[MEW-1:FRAC_BITS] + SHIFT_W'(op == OP_EXP_INOUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o   <= ctl_d;
      pct_o   <= percent_i;
      size_o  <= size_i;
      ma_o    <= ma_d;
      mb_o    <= mb_d;
      idx_o   <= idx_d;
      wgt_o   <= wgt_d;
      shift_o <= shift_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/eco_curve.sv
// ----------------------------------------------------------------------------
// eco_curve
// stages 2 to 4: table read, quadratic product, interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module eco_curve import eco_pkg::*; #(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic [2:0]             en_i,
  input  ctl_t                   ctl_i,
  input  logic [FRAC_BITS:0]     pct_i,
  input  logic [SIZE_W-1:0]      size_i,
  input  logic [FRAC_BITS+1:0]   ma_i,
  input  logic [FRAC_BITS+1:0]   mb_i,
  input  logic [TABLE_BITS:0]    idx_i,
  input  logic [FRAC_BITS-1:0]   wgt_i,
  input  logic [SHIFT_W-1:0]     shift_i,
  output ctl_t                   ctl_o,
  output logic [FRAC_BITS:0]     pct_o,
  output logic [SIZE_W-1:0]      size_o,
  output logic [SHIFT_W-1:0]     shift_o,
  output logic [FRAC_BITS:0]     qe_o,
  output logic [FRAC_BITS:0]     tv_o
);

  localparam int unsigned W     = FRAC_BITS + 1;
  localparam int unsigned MW    = FRAC_BITS + 2;
  localparam int unsigned PW    = 2 * MW + 1;
  localparam int unsigned LW    = W + FRAC_BITS;
  localparam int unsigned IW    = TABLE_BITS + 1;
  localparam int unsigned TAB_N = 1 << TABLE_BITS;
  localparam logic [W-1:0]  ONE    = W'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic [LW:0]   HALF_L = (LW + 1)'(1) << (FRAC_BITS - 1);

  // constant tables
  logic [W-1:0] exp_rom [TAB_N+1];
  logic [W-1:0] sin_rom [TAB_N+1];

  for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
    localparam logic [W-1:0] EV = W'(exp_entry(g, FRAC_BITS, TABLE_BITS));
    localparam logic [W-1:0] SV = W'(sin_entry(g, FRAC_BITS, TABLE_BITS));
    assign exp_rom[g] = EV;
    assign sin_rom[g] = SV;
  end

  // stage 2
  logic [IW-1:0]      idx_n;
  logic [W-1:0]       ta, tb;
  ctl_t               ctl2_q;
  logic [W-1:0]       pct2_q;
  logic [SIZE_W-1:0]  size2_q;
  logic [SHIFT_W-1:0] shift2_q;
  logic [FRAC_BITS-1:0] wgt2_q;
  logic [W-1:0]       a2_q, diff2_q;
  logic               neg2_q;
  logic [2*MW-1:0]    prod2_q;

  always_comb begin
    idx_n = (idx_i == IW'(TAB_N)) ? idx_i : idx_i + 1'b1;
    if (ctl_i.op == OP_SINE) begin
      ta = sin_rom[idx_i];
      tb = sin_rom[idx_n];
    end else begin
      ta = exp_rom[idx_i];
      tb = exp_rom[idx_n];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ctl2_q   <= ctl_i;
      pct2_q   <= pct_i;
      size2_q  <= size_i;
      shift2_q <= shift_i;
      wgt2_q   <= wgt_i;
      a2_q     <= ta;
      neg2_q   <= tb < ta;
      diff2_q  <= (tb < ta) ? ta - tb : tb - ta;
      prod2_q  <= ma_i * mb_i;
    end
  end

  // stage 3
  logic [PW-1:0]      qsum;
  logic [W-1:0]       qr;
  ctl_t               ctl3_q;
  logic [W-1:0]       pct3_q;
  logic [SIZE_W-1:0]  size3_q;
  logic [SHIFT_W-1:0] shift3_q;
  logic [W-1:0]       a3_q;
  logic               neg3_q;
  logic [LW-1:0]      lm3_q;
  logic [W-1:0]       qe3_q;

  always_comb begin
    qsum = (PW'(prod2_q) << ctl2_q.dbl) + HALF_P;
    qr   = qsum[FRAC_BITS +: W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ctl3_q   <= ctl2_q;
      pct3_q   <= pct2_q;
      size3_q  <= size2_q;
      shift3_q <= shift2_q;
      a3_q     <= a2_q;
      neg3_q   <= neg2_q;
      lm3_q    <= diff2_q * wgt2_q;
      qe3_q    <= ctl2_q.sub ? ONE - qr : qr;
    end
  end

  // stage 4
  logic [LW:0]  lsum;
  logic [W-1:0] step;

  always_comb begin
    lsum = (LW + 1)'(lm3_q) + HALF_L;
    step = lsum[FRAC_BITS +: W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ctl_o   <= ctl3_q;
      pct_o   <= pct3_q;
      size_o  <= size3_q;
      shift_o <= shift3_q;
      qe_o    <= qe3_q;
      tv_o    <= neg3_q ? a3_q - step : a3_q + step;
    end
  end

endmodule

`default_nettype wire

// File: rtl/eco_output.sv
// ----------------------------------------------------------------------------
// eco_output
// stages 5 to 7: power of two shift, mode select, pixel scaling
// ----------------------------------------------------------------------------
`default_nettype none

module eco_output import eco_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic [2:0]             en_i,
  input  ctl_t                   ctl_i,
  input  logic [FRAC_BITS:0]     pct_i,
  input  logic [SIZE_W-1:0]      size_i,
  input  logic [SHIFT_W-1:0]     shift_i,
  input  logic [FRAC_BITS:0]     qe_i,
  input  logic [FRAC_BITS:0]     tv_i,
  output logic [FRAC_BITS:0]     eased_o,
  output logic [SIZE_W-1:0]      pixel_o,
  output logic                   bad_o
);

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned XW = SIZE_W + W;
  localparam logic [W-1:0]  ONE    = W'(1) << FRAC_BITS;
  localparam logic [XW:0]   HALF_X = (XW + 1)'(1) << (FRAC_BITS - 1);

  // stage 5
  logic [W:0]         rnd, psum;
  logic [W-1:0]       pw, e;
  logic [W-1:0]       e5_q;
  logic [SIZE_W-1:0]  size5_q;
  logic               bad5_q;

  always_comb begin
    rnd  = (shift_i == '0) ? '0 : (W + 1)'(1) << (shift_i - 1'b1);
    psum = ((W + 1)'(tv_i) + rnd) >> shift_i;
    pw   = psum[W-1:0];
    case (ctl_i.op)
      OP_LINEAR:     e = pct_i;
      OP_QUAD_IN:    e = qe_i;
      OP_QUAD_OUT:   e = qe_i;
      OP_QUAD_INOUT: e = qe_i;
      OP_EXP_IN:     e = pw;
      OP_EXP_OUT:    e = ONE - pw;
      OP_EXP_INOUT:  e = ctl_i.inv ? ONE - pw : pw;
      OP_SINE:       e = tv_i;
      default:       e = pct_i;
    endcase
    if (e > ONE) begin
      e = ONE;
    end
    if (ctl_i.bad) begin
      e = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      e5_q    <= e;
      size5_q <= size_i;
      bad5_q  <= ctl_i.bad;
    end
  end

  // stage 6
  logic [XW-1:0] pm6_q;
  logic [W-1:0]  e6_q;
  logic          bad6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pm6_q  <= size5_q * e5_q;
      e6_q   <= e5_q;
      bad6_q <= bad5_q;
    end
  end

  // stage 7
  logic [XW:0] xsum;

  assign xsum = (XW + 1)'(pm6_q) + HALF_X;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      eased_o <= e6_q;
      pixel_o <= xsum[FRAC_BITS +: SIZE_W];
      bad_o   <= bad6_q;
    end
  end

endmodule

`default_nettype wire

// File: bench/eco_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eco_result_check
// watches both channels of the easing curve evaluator, predicts each result
// from the accepted request and compares it field by field in arrival order
// ----------------------------------------------------------------------------

module eco_result_check import eco_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  eco_in_if           in_mon,
  eco_out_if          out_mon,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  localparam int unsigned FB     = FRAC_BITS_DEF;
  localparam int unsigned TB     = TABLE_BITS_DEF;
  localparam int unsigned ROM_N  = 1 << TB;
  localparam int unsigned SER_FB = 30;
  localparam logic [63:0] SER_ONE = 64'd1 << SER_FB;
  localparam logic [63:0] PI_SER  = 64'd3373259426;
  localparam logic [63:0] LN2_SER = 64'd744261118;
  localparam logic [63:0] ONE     = 64'd1 << FB;
  localparam logic [63:0] HALF    = ONE >> 1;
  localparam logic [63:0] FMASK   = ONE - 64'd1;

  typedef struct {
    logic [FB:0]       pct;
    op_e               op;
    logic [SIZE_W-1:0] size;
    logic [FB:0]       eased;
    logic [SIZE_W-1:0] pixel;
    logic              bad;
  } curve_point_t;

  logic [63:0]  pow2_rom [0:ROM_N];
  logic [63:0]  sine_rom [0:ROM_N];
  curve_point_t due_points [$];

  // series result at 30 fractional bits down to Q.FB, capped at 1.0
  function automatic logic [63:0] round_to_q(input logic [63:0] r);
    logic [63:0] v;
    v = (r + (64'd1 << (SER_FB - FB - 1))) >> (SER_FB - FB);
    return (v > ONE) ? ONE : v;
  endfunction

  // linear interpolation between neighboring entries, position in Q.FB
  function automatic logic [63:0] interp(input logic [63:0] rom [0:ROM_N],
                                         input logic [63:0] pos);
    logic [63:0] idx;
    logic [63:0] w;
    logic [63:0] a;
    logic [63:0] b;
    idx = pos >> FB;
    w   = pos & FMASK;
    if (idx >= ROM_N) return rom[ROM_N];
    a = rom[idx];
    b = rom[idx + 1];
    if (b >= a) return a + (((b - a) * w + HALF) >> FB);
    return a - (((a - b) * w + HALF) >> FB);
  endfunction

  // 2^(-m), m in Q.FB, with extra halvings
  function automatic logic [63:0] pow2_neg(input logic [63:0] m, input int unsigned extra);
    logic [63:0] v;
    logic [63:0] sh;
    v  = interp(pow2_rom, (m & FMASK) << TB);
    sh = (m >> FB) + 64'(extra);
    if (sh == 0) return v;
    if (sh >= 63) return 64'd0;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic curve_point_t eval_curve(input logic [FB:0] pct, input op_e op,
                                              input logic [SIZE_W-1:0] size);
    curve_point_t pt;
    logic [63:0]  p;
    logic [63:0]  q;
    logic [63:0]  e;
    logic [63:0]  prod;
    pt.pct  = pct;
    pt.op   = op;
    pt.size = size;
    p = 64'(pct);
    if (p > ONE) begin
      pt.eased = '0;
      pt.pixel = '0;
      pt.bad   = 1'b1;
      return pt;
    end
    case (op)
      OP_QUAD_IN:  e = (p * p + HALF) >> FB;
      OP_QUAD_OUT: e = ((2 * ONE - p) * p + HALF) >> FB;
      OP_QUAD_INOUT: begin
        if (p < HALF) begin
          e = (2 * p * p + HALF) >> FB;
        end else begin
          q = ONE - p;
          e = ONE - ((2 * q * q + HALF) >> FB);
        end
      end
      OP_EXP_IN:  e = pow2_neg(10 * (ONE - p), 0);
      OP_EXP_OUT: e = ONE - pow2_neg(10 * p, 0);
      OP_EXP_INOUT: begin
        if (p < HALF) e = pow2_neg(10 * (ONE - 2 * p), 1);
        else e = ONE - pow2_neg(10 * (2 * p - ONE), 1);
      end
      OP_SINE: begin
        q = (p <= HALF) ? p : ONE - p;
        e = interp(sine_rom, q << (TB + 1));
      end
      default: e = p;
    endcase
    if (e > ONE) e = ONE;
    prod     = 64'(size) * e + HALF;
    pt.eased = e[FB:0];
    pt.pixel = prod[FB +: SIZE_W];
    pt.bad   = 1'b0;
    return pt;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches_o = mismatches_o + 1;
  endtask

  // power-of-two and sine tables from alternating series
  initial begin : build_roms
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] th2;
    mismatches_o  = 0;
    outstanding_o = 0;
    for (int i = 0; i <= ROM_N; i++) begin
      x    = 64'(i) << (SER_FB - TB);
      y    = (x * LN2_SER) >> SER_FB;
      pos  = SER_ONE;
      neg  = '0;
      term = SER_ONE;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * y) >> SER_FB) / 64'(k);
        if (k % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      pow2_rom[i] = round_to_q((pos > neg) ? pos - neg : 64'd0);
      x    = (PI_SER * 64'(i)) >> (TB + 1);
      th2  = (x * x) >> SER_FB;
      pos  = x;
      neg  = '0;
      term = x;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * th2) >> SER_FB) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      sine_rom[i] = round_to_q((pos > neg) ? pos - neg : 64'd0);
    end
  end

  always @(posedge clk_i) begin : watch
    curve_point_t want;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        due_points.push_back(eval_curve(in_mon.percent, op_e'(in_mon.operation),
                                        in_mon.size));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_points.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          want = due_points.pop_front();
          if (out_mon.eased !== want.eased)
            report_mismatch($sformatf("eased %s pct %0d size %0d: got %0d, want %0d",
              want.op.name(), want.pct, want.size, out_mon.eased, want.eased));
          if (out_mon.pixel !== want.pixel)
            report_mismatch($sformatf("pixel %s pct %0d size %0d: got %0d, want %0d",
              want.op.name(), want.pct, want.size, out_mon.pixel, want.pixel));
          if (out_mon.bad_percent !== want.bad)
            report_mismatch($sformatf("bad_percent %s pct %0d: got %b, want %b",
              want.op.name(), want.pct, out_mon.bad_percent, want.bad));
        end
      end
      outstanding_o = due_points.size();
    end
  end

endmodule

// File: bench/easing_curve_evaluator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// easing_curve_evaluator_test
// drives directed corner cases and random requests through the evaluator
// with random idling on both channels, a long output hold-off and a drain
// pause; results are predicted and compared by eco_result_check
// ----------------------------------------------------------------------------

module easing_curve_evaluator_test;
  import eco_pkg::*;

  localparam int unsigned FB          = FRAC_BITS_DEF;
  localparam int unsigned ONE_Q       = 1 << FB;
  localparam int unsigned HALF_Q      = ONE_Q >> 1;
  localparam int unsigned MAX_PCT     = (1 << (FB + 1)) - 1;
  localparam int unsigned MAX_SIZE    = (1 << SIZE_W) - 1;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count;

  // handshakes between the request side and the result side
  bit          calm;         // final stretch: no idling anywhere
  bit          hold_wanted;  // ask the result side for a long hold-off
  bit          hold_active;  // result side is holding ready low

  eco_in_if  in_ch ();
  eco_out_if out_ch ();

  easing_curve_evaluator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  eco_result_check result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // watchdog: a hung handshake or a lost result ends here
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // progress: mostly in range, some corners at 0 and around 0.5 and 1.0, some above 1.0
  function automatic int unsigned pick_progress();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return $urandom_range(ONE_Q + 1, MAX_PCT);
      1: begin
        case ($urandom_range(0, 7))
          0: return 0;
          1: return 1;
          2: return HALF_Q - 1;
          3: return HALF_Q;
          4: return HALF_Q + 1;
          5: return ONE_Q - 1;
          6: return ONE_Q;
          default: return ONE_Q + 1;
        endcase
      end
      default: return $urandom_range(0, ONE_Q);
    endcase
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return MAX_SIZE;
      2: return $urandom_range(0, 15);
      default: return $urandom_range(0, MAX_SIZE);
    endcase
  endfunction

  // offer one request transaction and hold it until taken
  task automatic send_request(input int unsigned pct, input op_e op,
                              input int unsigned size);
    @(negedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.percent   <= (FB + 1)'(pct);
    in_ch.operation <= op;
    in_ch.size      <= SIZE_W'(size);
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // drop valid for an idle gap of length n; payload wiggles to show it is ignored
  task automatic idle_request(input int unsigned n);
    @(negedge clk_i);
    in_ch.valid     <= 1'b0;
    in_ch.percent   <= (FB + 1)'($urandom_range(0, MAX_PCT));
    in_ch.operation <= op_e'($urandom_range(0, 7));
    in_ch.size      <= SIZE_W'($urandom_range(0, MAX_SIZE));
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (!calm && $urandom_range(0, 5) == 0) idle_request($urandom_range(1, 12));
      send_request(pick_progress(), op_e'($urandom_range(0, 7)), pick_size());
    end
  endtask

  // result side: random ready bursts, one long hold-off on request,
  // always ready once the run is calm
  initial begin : result_side
    int unsigned len;
    out_ch.ready = 1'b0;
    hold_active  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_active = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_active = 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 12);
        out_ch.ready <= 1'b0;
        repeat (len - 1) @(negedge clk_i);
      end else begin
        len = $urandom_range(1, 24);
        out_ch.ready <= 1'b1;
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : request_side
    in_ch.valid     = 1'b0;
    in_ch.percent   = '0;
    in_ch.operation = OP_LINEAR;
    in_ch.size      = '0;
    calm            = 1'b0;
    hold_wanted     = 1'b0;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every curve at both ends of the range, full-scale size
    for (int k = 0; k < 8; k++) send_request(0, op_e'(k), MAX_SIZE);
    for (int k = 0; k < 8; k++) send_request(ONE_Q, op_e'(k), MAX_SIZE);
    // branch points of the in-out curves and the sine fold
    send_request(HALF_Q - 1, OP_QUAD_INOUT, 1);
    send_request(HALF_Q, OP_QUAD_INOUT, 1);
    send_request(HALF_Q - 1, OP_EXP_INOUT, 1);
    send_request(HALF_Q, OP_EXP_INOUT, 1);
    send_request(HALF_Q, OP_SINE, MAX_SIZE);
    send_request(HALF_Q + 1, OP_SINE, MAX_SIZE);
    // progress just above 1.0 and at the top of the field
    send_request(ONE_Q + 1, OP_QUAD_OUT, MAX_SIZE);
    send_request(MAX_PCT, OP_SINE, MAX_SIZE);
    send_request(1, OP_LINEAR, 0);

    // sender pause: let every outstanding result drain first
    idle_request(1);
    wait (outstanding == 0);

    send_random(200);

    // long receiver hold-off while requests keep coming back to back,
    // enough to fill all stages and stall the input
    idle_request(1);
    hold_wanted = 1'b1;
    wait (hold_active);
    for (int unsigned n = 0; n < 30; n++) begin
      send_request(pick_progress(), op_e'($urandom_range(0, 7)), pick_size());
    end

    send_random(200);

    // final stretch at full rate on both sides
    calm = 1'b1;
    send_random(60);
    idle_request(1);

    wait (outstanding == 0);
    repeat (4 * NSTG) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
